// ----- hdl/ycc_pkg.sv -----
// Shared types and constants for the YCbCr to RGB converter.
// Depends on nothing; every other file of the block imports it.
package ycc_pkg;

  localparam int SAMPLE_W   = 16;  // width of one input sample field
  localparam int COEF_W     = 19;  // signed coefficient width, scale 2^16
  localparam int RGB_W      = 8;   // width of one output component
  localparam int DEPTH_W    = 5;   // width of the sample depth register
  localparam int CFG_IDX_W  = 3;   // register index width
  localparam int CFG_DATA_W = 19;  // widest register

  localparam int MIN_DEPTH       = 8;
  localparam int LUMA_OFS_BASE   = 16;
  localparam int CHROMA_OFS_BASE = 128;
  localparam int SHIFT_BASE      = 8;
  localparam int RGB_MAX         = 255;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_DEPTH  = 3'd0,
    REG_FULL_RANGE    = 3'd1,
    REG_COEF_LUMA     = 3'd2,
    REG_COEF_RED_CR   = 3'd3,
    REG_COEF_GREEN_CB = 3'd4,
    REG_COEF_GREEN_CR = 3'd5,
    REG_COEF_BLUE_CB  = 3'd6
  } cfg_reg_t;

  // Reset values (BT.709 full range)
  localparam logic [DEPTH_W-1:0]       RST_SAMPLE_DEPTH  = 5'd8;
  localparam logic                     RST_FULL_RANGE    = 1'b1;
  localparam logic signed [COEF_W-1:0] RST_COEF_LUMA     = 19'sd65536;
  localparam logic signed [COEF_W-1:0] RST_COEF_RED_CR   = 19'sd103206;
  localparam logic signed [COEF_W-1:0] RST_COEF_GREEN_CB = -19'sd12276;
  localparam logic signed [COEF_W-1:0] RST_COEF_GREEN_CR = -19'sd30679;
  localparam logic signed [COEF_W-1:0] RST_COEF_BLUE_CB  = 19'sd121608;

  // Settings seen by the offset, multiplier and clamp stages; depth is already clamped
  typedef struct packed {
    logic [DEPTH_W-1:0]       depth;
    logic                     full_range;
    logic signed [COEF_W-1:0] coef_luma;
    logic signed [COEF_W-1:0] coef_red_cr;
    logic signed [COEF_W-1:0] coef_green_cb;
    logic signed [COEF_W-1:0] coef_green_cr;
    logic signed [COEF_W-1:0] coef_blue_cb;
  } ycc_cfg_t;

endpackage

// ----- hdl/ycc_pix_if.sv -----
// Input pixel channel: valid/ready handshake with Y, Cb and Cr samples.
// Depends on ycc_pkg.
interface ycc_pix_if;
  import ycc_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] luma;
  logic [SAMPLE_W-1:0] chroma_blue;
  logic [SAMPLE_W-1:0] chroma_red;

  modport source (output valid, luma, chroma_blue, chroma_red, input ready);
  modport sink   (input valid, luma, chroma_blue, chroma_red, output ready);
endinterface

// ----- hdl/ycc_rgb_if.sv -----
// Output pixel channel: valid/ready handshake with 8-bit R, G and B.
// Depends on ycc_pkg.
interface ycc_rgb_if;
  import ycc_pkg::*;

  logic             valid;
  logic             ready;
  logic [RGB_W-1:0] red;
  logic [RGB_W-1:0] green;
  logic [RGB_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// ----- hdl/ycbcr_to_rgb_converter.sv -----
// YCbCr to RGB converter, top level. Built on ycc_pkg, the two channel
// interfaces and the four pipeline stages ycc_offset, ycc_mult, ycc_sum and
// ycc_clamp. The block takes one pixel per clock unless stalled and returns
// its 8-bit R, G and B: stage one masks the samples to the active depth and
// removes the offsets, stage two forms the five coefficient products (one
// 19 x 17 bit multiplier each), stage three adds them into exact sums, and
// stage four does the floor shift by depth plus eight and the saturation
// into the output register. Sustained rate is one pixel per cycle unless the
// output stalls; the figure is set by the single multiplier stage, each
// product getting its own multiplier. Every stage has its own valid bit and
// its ready looks only at the next stage, so a stalled output still lets
// bubbles upstream fill and new pixels come in. Write the configuration
// registers only while no pixel is in flight; out-of-range depths clamp to
// 8..SAMPLE_BITS and writes to unknown indexes are dropped.
module ycbcr_to_rgb_converter #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  ycc_pix_if.sink                       pix,
  ycc_rgb_if.source                     rgb,
  input  logic                          cfg_we,
  input  logic [ycc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ycc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ycc_pkg::*;

  localparam int PW = SAMPLE_BITS + COEF_W + 1;
  localparam int SW = SAMPLE_BITS + COEF_W + 3;

  // Configuration registers
  logic [DEPTH_W-1:0]       sample_depth;
  logic                     full_range;
  logic signed [COEF_W-1:0] coef_luma;
  logic signed [COEF_W-1:0] coef_red_cr;
  logic signed [COEF_W-1:0] coef_green_cb;
  logic signed [COEF_W-1:0] coef_green_cr;
  logic signed [COEF_W-1:0] coef_blue_cb;

  logic [DEPTH_W-1:0] depth_eff;
  ycc_cfg_t           cfg;

  // Stage links
  logic                       v1, r1, v2, r2, v3, r3;
  logic signed [SAMPLE_BITS:0] y, u, v;
  logic signed [PW-1:0]       p_ly, p_rv, p_gu, p_gv, p_bu;
  logic signed [SW-1:0]       sum_red, sum_green, sum_blue;

  // Capture register writes; unknown indexes fall through and are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_depth  <= RST_SAMPLE_DEPTH;
      full_range    <= RST_FULL_RANGE;
      coef_luma     <= RST_COEF_LUMA;
      coef_red_cr   <= RST_COEF_RED_CR;
      coef_green_cb <= RST_COEF_GREEN_CB;
      coef_green_cr <= RST_COEF_GREEN_CR;
      coef_blue_cb  <= RST_COEF_BLUE_CB;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SAMPLE_DEPTH:  sample_depth  <= cfg_data[DEPTH_W-1:0];
        REG_FULL_RANGE:    full_range    <= cfg_data[0];
        REG_COEF_LUMA:     coef_luma     <= $signed(cfg_data[COEF_W-1:0]);
        REG_COEF_RED_CR:   coef_red_cr   <= $signed(cfg_data[COEF_W-1:0]);
        REG_COEF_GREEN_CB: coef_green_cb <= $signed(cfg_data[COEF_W-1:0]);
        REG_COEF_GREEN_CR: coef_green_cr <= $signed(cfg_data[COEF_W-1:0]);
        REG_COEF_BLUE_CB:  coef_blue_cb  <= $signed(cfg_data[COEF_W-1:0]);
        default: ;
      endcase
    end
  end

  // Clamp the depth into the supported range
  always_comb begin
    priority if (sample_depth < DEPTH_W'(MIN_DEPTH)) begin
      depth_eff = DEPTH_W'(MIN_DEPTH);
    end else if (sample_depth > DEPTH_W'(SAMPLE_BITS)) begin
      depth_eff = DEPTH_W'(SAMPLE_BITS);
    end else begin
      depth_eff = sample_depth;
    end
  end

  assign cfg.depth         = depth_eff;
  assign cfg.full_range    = full_range;
  assign cfg.coef_luma     = coef_luma;
  assign cfg.coef_red_cr   = coef_red_cr;
  assign cfg.coef_green_cb = coef_green_cb;
  assign cfg.coef_green_cr = coef_green_cr;
  assign cfg.coef_blue_cb  = coef_blue_cb;

  ycc_offset #(.SAMPLE_BITS(SAMPLE_BITS)) u_offset (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .up_valid    (pix.valid),
    .up_ready    (pix.ready),
    .luma        (pix.luma),
    .chroma_blue (pix.chroma_blue),
    .chroma_red  (pix.chroma_red),
    .dn_valid    (v1),
    .dn_ready    (r1),
    .y           (y),
    .u           (u),
    .v           (v)
  );

  ycc_mult #(.SAMPLE_BITS(SAMPLE_BITS)) u_mult (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (v1),
    .up_ready (r1),
    .y        (y),
    .u        (u),
    .v        (v),
    .dn_valid (v2),
    .dn_ready (r2),
    .p_ly     (p_ly),
    .p_rv     (p_rv),
    .p_gu     (p_gu),
    .p_gv     (p_gv),
    .p_bu     (p_bu)
  );

  ycc_sum #(.SAMPLE_BITS(SAMPLE_BITS)) u_sum (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (v2),
    .up_ready  (r2),
    .p_ly      (p_ly),
    .p_rv      (p_rv),
    .p_gu      (p_gu),
    .p_gv      (p_gv),
    .p_bu      (p_bu),
    .dn_valid  (v3),
    .dn_ready  (r3),
    .sum_red   (sum_red),
    .sum_green (sum_green),
    .sum_blue  (sum_blue)
  );

  ycc_clamp #(.SAMPLE_BITS(SAMPLE_BITS)) u_clamp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .up_valid  (v3),
    .up_ready  (r3),
    .sum_red   (sum_red),
    .sum_green (sum_green),
    .sum_blue  (sum_blue),
    .dn_valid  (rgb.valid),
    .dn_ready  (rgb.ready),
    .red       (rgb.red),
    .green     (rgb.green),
    .blue      (rgb.blue)
  );

  // Clamped depth always lies in the supported range
  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    depth_eff >= DEPTH_W'(MIN_DEPTH) && depth_eff <= DEPTH_W'(SAMPLE_BITS))
    else $error("effective depth out of range");

  // A full pipeline behind a stalled output must hold off the input
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && v1 && v2 && v3 && rgb.valid && !rgb.ready) |-> !pix.ready)
    else $error("input taken while pipeline full and stalled");

  // A negative red sum that moves into the output register saturates to zero
  a_red_floor: assert property (@(posedge clk) disable iff (rst)
    (v3 && r3 && sum_red[SW-1]) |=> (rgb.red == '0))
    else $error("negative red sum not clamped to zero");

  // A transfer into an empty stage one passes the pixel on to stage two
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.ready && !v1) |=> v1)
    else $error("accepted pixel lost at stage one");
endmodule

// ----- hdl/ycc_offset.sv -----
// Stage 1: mask samples to the active depth and remove luma/chroma offsets.
// Depends on ycc_pkg.
module ycc_offset #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ycc_pkg::ycc_cfg_t                cfg,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  logic [ycc_pkg::SAMPLE_W-1:0]     luma,
  input  logic [ycc_pkg::SAMPLE_W-1:0]     chroma_blue,
  input  logic [ycc_pkg::SAMPLE_W-1:0]     chroma_red,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output logic signed [SAMPLE_BITS:0]      y,
  output logic signed [SAMPLE_BITS:0]      u,
  output logic signed [SAMPLE_BITS:0]      v
);
  import ycc_pkg::*;

  logic [SAMPLE_BITS-1:0] mask;
  logic [DEPTH_W-1:0]     scale;
  logic [SAMPLE_BITS-1:0] luma_ofs;
  logic [SAMPLE_BITS-1:0] chroma_ofs;
  logic [SAMPLE_BITS-1:0] y_raw;
  logic [SAMPLE_BITS-1:0] u_raw;
  logic [SAMPLE_BITS-1:0] v_raw;

  assign mask       = ~({SAMPLE_BITS{1'b1}} << cfg.depth);
  assign scale      = cfg.depth - DEPTH_W'(MIN_DEPTH);
  assign luma_ofs   = cfg.full_range ? '0 : (SAMPLE_BITS'(LUMA_OFS_BASE) << scale);
  assign chroma_ofs = SAMPLE_BITS'(CHROMA_OFS_BASE) << scale;
  assign y_raw      = luma[SAMPLE_BITS-1:0] & mask;
  assign u_raw      = chroma_blue[SAMPLE_BITS-1:0] & mask;
  assign v_raw      = chroma_red[SAMPLE_BITS-1:0] & mask;

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      y <= $signed({1'b0, y_raw}) - $signed({1'b0, luma_ofs});
      u <= $signed({1'b0, u_raw}) - $signed({1'b0, chroma_ofs});
      v <= $signed({1'b0, v_raw}) - $signed({1'b0, chroma_ofs});
    end
  end
endmodule

// ----- hdl/ycc_mult.sv -----
// Stage 2: the five coefficient products, one multiplier each.
// Depends on ycc_pkg.
module ycc_mult #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  ycc_pkg::ycc_cfg_t                          cfg,
  input  logic                                       up_valid,
  output logic                                       up_ready,
  input  logic signed [SAMPLE_BITS:0]                y,
  input  logic signed [SAMPLE_BITS:0]                u,
  input  logic signed [SAMPLE_BITS:0]                v,
  output logic                                       dn_valid,
  input  logic                                       dn_ready,
  output logic signed [SAMPLE_BITS+ycc_pkg::COEF_W:0] p_ly,
  output logic signed [SAMPLE_BITS+ycc_pkg::COEF_W:0] p_rv,
  output logic signed [SAMPLE_BITS+ycc_pkg::COEF_W:0] p_gu,
  output logic signed [SAMPLE_BITS+ycc_pkg::COEF_W:0] p_gv,
  output logic signed [SAMPLE_BITS+ycc_pkg::COEF_W:0] p_bu
);
  import ycc_pkg::*;

  localparam int PW = SAMPLE_BITS + COEF_W + 1;

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      p_ly <= PW'(y) * PW'(cfg.coef_luma);
      p_rv <= PW'(v) * PW'(cfg.coef_red_cr);
      p_gu <= PW'(u) * PW'(cfg.coef_green_cb);
      p_gv <= PW'(v) * PW'(cfg.coef_green_cr);
      p_bu <= PW'(u) * PW'(cfg.coef_blue_cb);
    end
  end
endmodule

// ----- hdl/ycc_sum.sv -----
// Stage 3: add the products into the three exact component sums.
// Depends on ycc_pkg.
module ycc_sum #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         up_valid,
  output logic                                         up_ready,
  input  logic signed [SAMPLE_BITS+ycc_pkg::COEF_W:0]   p_ly,
  input  logic signed [SAMPLE_BITS+ycc_pkg::COEF_W:0]   p_rv,
  input  logic signed [SAMPLE_BITS+ycc_pkg::COEF_W:0]   p_gu,
  input  logic signed [SAMPLE_BITS+ycc_pkg::COEF_W:0]   p_gv,
  input  logic signed [SAMPLE_BITS+ycc_pkg::COEF_W:0]   p_bu,
  output logic                                         dn_valid,
  input  logic                                         dn_ready,
  output logic signed [SAMPLE_BITS+ycc_pkg::COEF_W+2:0] sum_red,
  output logic signed [SAMPLE_BITS+ycc_pkg::COEF_W+2:0] sum_green,
  output logic signed [SAMPLE_BITS+ycc_pkg::COEF_W+2:0] sum_blue
);
  import ycc_pkg::*;

  localparam int SW = SAMPLE_BITS + COEF_W + 3;

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      sum_red   <= SW'(p_ly) + SW'(p_rv);
      sum_green <= SW'(p_ly) + SW'(p_gu) + SW'(p_gv);
      sum_blue  <= SW'(p_ly) + SW'(p_bu);
    end
  end
endmodule

// ----- hdl/ycc_clamp.sv -----
// Stage 4: floor shift by depth plus eight and saturate to 0..255.
// Depends on ycc_pkg.
module ycc_clamp #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  ycc_pkg::ycc_cfg_t                            cfg,
  input  logic                                         up_valid,
  output logic                                         up_ready,
  input  logic signed [SAMPLE_BITS+ycc_pkg::COEF_W+2:0] sum_red,
  input  logic signed [SAMPLE_BITS+ycc_pkg::COEF_W+2:0] sum_green,
  input  logic signed [SAMPLE_BITS+ycc_pkg::COEF_W+2:0] sum_blue,
  output logic                                         dn_valid,
  input  logic                                         dn_ready,
  output logic [ycc_pkg::RGB_W-1:0]                    red,
  output logic [ycc_pkg::RGB_W-1:0]                    green,
  output logic [ycc_pkg::RGB_W-1:0]                    blue
);
  import ycc_pkg::*;

  localparam int SW = SAMPLE_BITS + COEF_W + 3;

  logic [DEPTH_W-1:0] shift;
  logic signed [SW-1:0] q_red;
  logic signed [SW-1:0] q_green;
  logic signed [SW-1:0] q_blue;

  function automatic logic [RGB_W-1:0] sat8(input logic signed [SW-1:0] q);
    logic [RGB_W-1:0] r;
    if (q[SW-1]) begin
      r = '0;
    end else if (q > SW'(RGB_MAX)) begin
      r = RGB_W'(RGB_MAX);
    end else begin
      r = q[RGB_W-1:0];
    end
    return r;
  endfunction

  assign shift   = cfg.depth + DEPTH_W'(SHIFT_BASE);
  assign q_red   = sum_red >>> shift;
  assign q_green = sum_green >>> shift;
  assign q_blue  = sum_blue >>> shift;

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      red   <= sat8(q_red);
      green <= sat8(q_green);
      blue  <= sat8(q_blue);
    end
  end
endmodule
